// File: hw/rtl/twfm_pkg.sv
// Package for the tile wipe and fade mask engine.
// Holds grid constants, codes, state and the command and status types.
// Used by every module of the block except twfm_ram; depends on nothing.
package twfm_pkg;

    localparam int COLS     = 20;
    localparam int ROWS     = 15;
    localparam int CELLS    = ROWS * COLS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int COL_W    = $clog2(COLS);
    localparam int ROW_W    = 4;
    localparam int IN_COL_W = 6;
    localparam int WAVE_W   = 7;
    localparam int LVL_W    = 4;
    localparam int ENTRY_W  = LVL_W + 1;
    localparam int DIR_W    = 3;
    localparam int ACT_W    = 2;

    localparam logic [LVL_W-1:0] LVL_MAX = 4'd15;
    localparam logic [7:0] LAST_ROW = 8'd14;
    localparam logic [ROW_W-1:0] HALF_ROWS = 4'd7;

    localparam logic [DIR_W-1:0] PAT_LEFT    = 3'd0;
    localparam logic [DIR_W-1:0] PAT_UP      = 3'd1;
    localparam logic [DIR_W-1:0] PAT_RIGHT   = 3'd2;
    localparam logic [DIR_W-1:0] PAT_DOWN    = 3'd3;
    localparam logic [DIR_W-1:0] PAT_DIAMOND = 3'd4;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK      = 2'd0,
        ACT_START_IN  = 2'd1,
        ACT_START_OUT = 2'd2,
        ACT_READ      = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_IN   = 2'd1,
        MODE_OUT  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_TICK,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic accept;
        logic sweep_write;
        logic sweep_read;
        logic tick_finish;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic active;
        logic out_free;
    } status_t;

endpackage

// File: hw/rtl/twfm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the cell store of the wipe engine.
module twfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/twfm_ctrl.sv
// Controller state machine of the wipe engine: sequences clear, fill,
// tick sweeps and result hand-off. Depends on twfm_pkg.
module twfm_ctrl import twfm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic [ACT_W-1:0] s_action,
    output logic             s_ready,
    input  status_t          status,
    output cmd_t             cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.sweep_write = 1'b1;
                if (status.last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    unique case (action_t'(s_action)) inside
                        ACT_TICK:                    state_next = status.active ? ST_TICK
                                                                                : ST_RESULT;
                        ACT_START_IN, ACT_START_OUT: state_next = ST_FILL;
                        ACT_READ:                    state_next = ST_RESULT;
                        default:                     state_next = ST_RESULT;
                    endcase
                end
            end
            ST_FILL: begin
                cmd.sweep_write = 1'b1;
                if (status.last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_TICK: begin
                cmd.sweep_read = 1'b1;
                if (status.last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                cmd.tick_finish = 1'b1;
                state_next      = ST_RESULT;
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// File: hw/rtl/twfm_dp.sv
// Datapath of the wipe engine: fade state, sweep counters, cell store,
// wavefront test, level stepping and the result register.
// Depends on twfm_pkg and twfm_ram.
module twfm_dp import twfm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [ACT_W-1:0]    s_action,
    input  logic [DIR_W-1:0]    s_direction,
    input  logic [ROW_W-1:0]    s_cell_row,
    input  logic [IN_COL_W-1:0] s_cell_col,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_fading,
    output logic                m_done_flag,
    output logic [LVL_W-1:0]    m_level
);

    mode_t              mode_reg, mode_next;
    logic [DIR_W-1:0]   pattern_reg, pattern_next;
    logic [WAVE_W-1:0]  wave_reg, wave_next, wave_inc;
    logic               complete_reg, complete_next;

    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic               wb_valid_reg;
    logic [ADDR_W-1:0]  wb_addr_reg;
    logic [ROW_W-1:0]   wb_row_reg;
    logic [COL_W-1:0]   wb_col_reg;

    logic               is_read_reg, in_grid_reg;
    logic               m_valid_reg;
    logic               m_fading_reg, m_done_reg;
    logic [LVL_W-1:0]   m_level_reg;

    logic               fade_in, in_grid, rd_en, wr_en, front, mark_new;
    logic [ADDR_W-1:0]  item_addr, rd_addr, wr_addr;
    logic [ENTRY_W-1:0] wr_data, rd_data;
    logic [LVL_W-1:0]   lvl_old, lvl_new, fill_level;
    logic [7:0]         i8, j8, c8, v8, h8;

    assign fade_in    = (mode_reg == MODE_IN);
    assign fill_level = fade_in ? LVL_MAX : '0;
    assign in_grid    = (s_cell_row < ROW_W'(ROWS)) && ({1'b0, s_cell_col} < 7'(COLS));
    assign item_addr  = ADDR_W'(s_cell_row) * ADDR_W'(COLS) + ADDR_W'(s_cell_col);

    // Wavefront test for the cell in the write-back stage.
    always_comb begin
        i8 = 8'(wb_row_reg);
        j8 = 8'(wb_col_reg);
        c8 = 8'(wave_reg);
        v8 = (wb_row_reg < HALF_ROWS) ? i8 : LAST_ROW - i8;
        h8 = (wb_col_reg < COL_W'(COLS / 2)) ? j8 : 8'(COLS - 1) - j8;
        case (pattern_reg)
            PAT_LEFT:    front = (j8 + c8 == 8'(COLS - 1));
            PAT_UP:      front = (i8 + c8 == LAST_ROW);
            PAT_RIGHT:   front = (j8 == c8);
            PAT_DOWN:    front = (i8 == c8);
            PAT_DIAMOND: front = fade_in ? (v8 + h8 + c8 == 8'(COLS - 1))
                                         : (v8 + h8 == c8);
            default:     front = 1'b0;
        endcase
    end

    always_comb begin
        lvl_old  = rd_data[LVL_W-1:0];
        mark_new = rd_data[LVL_W] | front;
        lvl_new  = lvl_old;
        if (mark_new) begin
            if (fade_in) begin
                if (lvl_old != '0) begin
                    lvl_new = lvl_old - 1'b1;
                end
            end else if (lvl_old != LVL_MAX) begin
                lvl_new = lvl_old + 1'b1;
            end
        end
    end

    always_comb begin
        rd_en   = cmd.sweep_read || (cmd.accept && action_t'(s_action) == ACT_READ);
        rd_addr = cmd.sweep_read ? addr_reg : item_addr;
        wr_en   = cmd.sweep_write || wb_valid_reg;
        wr_addr = cmd.sweep_write ? addr_reg : wb_addr_reg;
        wr_data = cmd.sweep_write ? {1'b0, fill_level} : {mark_new, lvl_new};
    end

    twfm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CELLS)
    ) u_cells (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sweep address counters walk the grid in row-major order.
    always_comb begin
        addr_next = addr_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        if (cmd.accept) begin
            addr_next = '0;
            row_next  = '0;
            col_next  = '0;
        end else if (cmd.sweep_write || cmd.sweep_read) begin
            addr_next = addr_reg + 1'b1;
            if (col_reg == COL_W'(COLS - 1)) begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb begin
        mode_next     = mode_reg;
        pattern_next  = pattern_reg;
        wave_next     = wave_reg;
        complete_next = complete_reg;
        wave_inc      = wave_reg + 1'b1;
        if (cmd.accept && action_t'(s_action) == ACT_START_IN) begin
            mode_next     = MODE_IN;
            pattern_next  = s_direction;
            wave_next     = '0;
            complete_next = 1'b0;
        end else if (cmd.accept && action_t'(s_action) == ACT_START_OUT) begin
            mode_next    = MODE_OUT;
            pattern_next = s_direction;
            wave_next    = '0;
        end else if (cmd.tick_finish) begin
            wave_next = wave_inc;
            if (fade_in) begin
                complete_next = 1'b0;
            end
            if (wave_inc > WAVE_W'(16 + COLS)) begin
                mode_next = MODE_IDLE;
                if (!fade_in) begin
                    complete_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            pattern_reg  <= '0;
            wave_reg     <= '0;
            complete_reg <= 1'b0;
            addr_reg     <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            wb_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            mode_reg     <= mode_next;
            pattern_reg  <= pattern_next;
            wave_reg     <= wave_next;
            complete_reg <= complete_next;
            addr_reg     <= addr_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            wb_valid_reg <= cmd.sweep_read;
            if (cmd.load_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        wb_addr_reg <= addr_reg;
        wb_row_reg  <= row_reg;
        wb_col_reg  <= col_reg;
        if (cmd.accept) begin
            is_read_reg <= (action_t'(s_action) == ACT_READ);
            in_grid_reg <= in_grid;
        end
        if (cmd.load_result) begin
            m_fading_reg <= (mode_reg != MODE_IDLE);
            m_done_reg   <= complete_reg;
            m_level_reg  <= (is_read_reg && in_grid_reg) ? rd_data[LVL_W-1:0] : '0;
        end
    end

    assign status.last     = (addr_reg == ADDR_W'(CELLS - 1));
    assign status.active   = (mode_reg != MODE_IDLE);
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_fading    = m_fading_reg;
    assign m_done_flag = m_done_reg;
    assign m_level     = m_level_reg;

endmodule

// File: hw/rtl/tile_wipe_fade_mask.sv
// Top level of the tile wipe and fade mask engine.
// Joins the controller twfm_ctrl and the datapath twfm_dp; depends on twfm_pkg.
//
// The grid of 15 rows by COLS columns lives in one RAM of 15*COLS entries, each
// holding a started mark and a 4-bit level. Every cell is visited once per
// tick or start request, through the one write port and the one read port of
// the RAM. A read request or a tick while no fade runs skips the sweep. After
// reset the block clears the RAM before it raises s_ready. One result is
// returned per request and reflects the state after that request.
module tile_wipe_fade_mask import twfm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACT_W-1:0]    s_action,
    input  logic [DIR_W-1:0]    s_direction,
    input  logic [ROW_W-1:0]    s_cell_row,
    input  logic [IN_COL_W-1:0] s_cell_col,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_fading,
    output logic                m_done_flag,
    output logic [LVL_W-1:0]    m_level
);

    cmd_t    cmd;
    status_t status;

    twfm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    twfm_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_action    (s_action),
        .s_direction (s_direction),
        .s_cell_row  (s_cell_row),
        .s_cell_col  (s_cell_col),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_fading    (m_fading),
        .m_done_flag (m_done_flag),
        .m_level     (m_level)
    );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for tile_wipe_fade_mask: sends start, tick and read requests with random gaps
// and result back-pressure, and checks every result against a model of the tile grid.
// Depends on twfm_pkg and the RTL of the block only.
module tb_top;
    import twfm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEM_TARGET    = 650;
    localparam int QUIET_TAIL     = 60;

    typedef struct packed {
        logic             fading;
        logic             done_flag;
        logic [LVL_W-1:0] level;
    } fade_status_t;

    class fade_scoreboard;
        mode_t             mode;
        logic [DIR_W-1:0]  pattern;
        logic [WAVE_W-1:0] wave;
        logic              complete;
        bit                marks[CELLS];
        logic [LVL_W-1:0]  levels[CELLS];
        fade_status_t      status_q[$];
        int                errors;

        function new();
            mode     = MODE_IDLE;
            pattern  = '0;
            wave     = '0;
            complete = 1'b0;
            errors   = 0;
            foreach (levels[k]) begin
                marks[k]  = 1'b0;
                levels[k] = '0;
            end
        endfunction

        function bit on_front(int i, int j, bit fade_in);
            int c, v, h, t;
            c = int'(wave);
            case (pattern)
                PAT_LEFT:  return j == COLS - 1 - c;
                PAT_UP:    return i == int'(LAST_ROW) - c;
                PAT_RIGHT: return j == c;
                PAT_DOWN:  return i == c;
                PAT_DIAMOND: begin
                    v = (i < int'(HALF_ROWS)) ? i : int'(LAST_ROW) - i;
                    h = (j < COLS / 2) ? j : COLS - 1 - j;
                    t = fade_in ? COLS - 1 - c : c;
                    return v + h == t;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void advance_wave();
            bit fade_in;
            int k;
            fade_in = (mode == MODE_IN);
            if (fade_in) begin
                complete = 1'b0;
            end
            for (int i = 0; i < ROWS; i++) begin
                for (int j = 0; j < COLS; j++) begin
                    k = i * COLS + j;
                    if (on_front(i, j, fade_in)) begin
                        marks[k] = 1'b1;
                    end
                    if (marks[k]) begin
                        if (fade_in && levels[k] != '0) begin
                            levels[k]--;
                        end else if (!fade_in && levels[k] != LVL_MAX) begin
                            levels[k]++;
                        end
                    end
                end
            end
            wave++;
            if (int'(wave) > int'(LVL_MAX) + COLS + 1) begin
                if (!fade_in) begin
                    complete = 1'b1;
                end
                mode = MODE_IDLE;
            end
        endfunction

        function void start_fade(bit fade_in, logic [DIR_W-1:0] dir);
            mode    = fade_in ? MODE_IN : MODE_OUT;
            pattern = dir;
            wave    = '0;
            foreach (levels[k]) begin
                marks[k]  = 1'b0;
                levels[k] = fade_in ? LVL_MAX : '0;
            end
            if (fade_in) begin
                complete = 1'b0;
            end
        endfunction

        // Returns 0 for a tick that finds no fade running, since the block leaves its state unchanged.
        function bit note_request(action_t act, logic [DIR_W-1:0] dir,
                                  logic [ROW_W-1:0] row, logic [IN_COL_W-1:0] col);
            fade_status_t want;
            bit counted;
            counted    = 1'b1;
            want.level = '0;
            case (act)
                ACT_TICK: begin
                    if (mode != MODE_IDLE) begin
                        advance_wave();
                    end else begin
                        counted = 1'b0;
                    end
                end
                ACT_START_IN:  start_fade(1'b1, dir);
                ACT_START_OUT: start_fade(1'b0, dir);
                default: begin
                    if (int'(row) < ROWS && int'(col) < COLS) begin
                        want.level = levels[int'(row) * COLS + int'(col)];
                    end
                end
            endcase
            want.fading    = (mode != MODE_IDLE);
            want.done_flag = complete;
            status_q.push_back(want);
            return counted;
        endfunction

        function void check_result(logic fading, logic done_flag, logic [LVL_W-1:0] level);
            fade_status_t want;
            if (status_q.size() == 0) begin
                $error("result with no request pending: fading %0d, done_flag %0d, level %0d",
                       fading, done_flag, level);
                errors++;
                return;
            end
            want = status_q.pop_front();
            if (fading !== want.fading) begin
                $error("fading: expected %0d, got %0d", want.fading, fading);
                errors++;
            end
            if (done_flag !== want.done_flag) begin
                $error("done_flag: expected %0d, got %0d", want.done_flag, done_flag);
                errors++;
            end
            if (level !== want.level) begin
                $error("level: expected %0d, got %0d", want.level, level);
                errors++;
            end
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    action_t             s_action    = ACT_TICK;
    logic [DIR_W-1:0]    s_direction = '0;
    logic [ROW_W-1:0]    s_cell_row  = '0;
    logic [IN_COL_W-1:0] s_cell_col  = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic                m_fading;
    logic                m_done_flag;
    logic [LVL_W-1:0]    m_level;

    fade_scoreboard sb;
    bit             quiet        = 1'b0;
    int             n_items      = 0;
    int             ready_hold   = 0;
    int             stall_cycles = 0;

    tile_wipe_fade_mask DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_direction (s_direction),
        .s_cell_row  (s_cell_row),
        .s_cell_col  (s_cell_col),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_fading    (m_fading),
        .m_done_flag (m_done_flag),
        .m_level     (m_level)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            ready_hold <= $urandom_range(0, 18);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_fading, m_done_flag, m_level);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_request(action_t act, logic [DIR_W-1:0] dir,
                                logic [ROW_W-1:0] row, logic [IN_COL_W-1:0] col);
        quiet = (n_items >= ITEM_TARGET - QUIET_TAIL);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_direction <= dir;
        s_cell_row  <= row;
        s_cell_col  <= col;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_items += sb.note_request(act, dir, row, col);
    endtask

    task automatic send_tick();
        send_request(ACT_TICK, DIR_W'($urandom), ROW_W'($urandom), IN_COL_W'($urandom));
    endtask

    task automatic send_read();
        logic [ROW_W-1:0]    row;
        logic [IN_COL_W-1:0] col;
        if ($urandom_range(0, 7) == 0) begin
            row = ROW_W'($urandom);
            col = IN_COL_W'($urandom);
        end else begin
            row = ROW_W'($urandom_range(0, ROWS - 1));
            col = IN_COL_W'($urandom_range(0, COLS - 1));
        end
        send_request(ACT_READ, DIR_W'($urandom), row, col);
    endtask

    initial begin
        int               n_ticks;
        action_t          act;
        logic [DIR_W-1:0] dir;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reads of the cleared grid at its corners and outside it, then a tick with no fade.
        send_request(ACT_READ, 3'd0, 4'd0, 6'd0);
        send_request(ACT_READ, 3'd7, 4'd14, 6'd19);
        send_request(ACT_READ, 3'd0, 4'd15, 6'd0);
        send_request(ACT_READ, 3'd0, 4'd0, 6'd63);
        send_request(ACT_TICK, 3'd7, 4'd15, 6'd63);

        // An unused pattern marks nothing, so the grid stays fully dark.
        send_request(ACT_START_IN, 3'd7, 4'd0, 6'd0);
        send_tick();
        send_request(ACT_READ, 3'd0, 4'd7, 6'd10);

        // Each pattern in turn; every start restarts the fade that is running.
        send_request(ACT_START_OUT, PAT_DIAMOND, 4'd0, 6'd0);
        send_tick();
        send_tick();
        send_request(ACT_READ, 3'd0, 4'd14, 6'd19);
        send_request(ACT_START_IN, PAT_LEFT, 4'd0, 6'd0);
        send_tick();
        send_request(ACT_READ, 3'd0, 4'd0, 6'd19);
        send_request(ACT_START_OUT, PAT_UP, 4'd0, 6'd0);
        send_tick();
        send_request(ACT_READ, 3'd0, 4'd14, 6'd0);
        send_request(ACT_START_IN, PAT_RIGHT, 4'd0, 6'd0);
        send_tick();
        send_request(ACT_READ, 3'd0, 4'd3, 6'd0);
        send_request(ACT_START_OUT, PAT_DOWN, 4'd0, 6'd0);
        send_tick();
        send_request(ACT_READ, 3'd0, 4'd0, 6'd5);

        while (n_items < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 7) begin
                act = $urandom_range(0, 1) ? ACT_START_IN : ACT_START_OUT;
                dir = ($urandom_range(0, 5) == 0) ? DIR_W'($urandom_range(5, 7))
                                                  : DIR_W'($urandom_range(0, 4));
                send_request(act, dir, ROW_W'($urandom), IN_COL_W'($urandom));
                n_ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 36)
                                                      : $urandom_range(37, 40);
                repeat (n_ticks) begin
                    send_tick();
                    if ($urandom_range(0, 2) == 0) begin
                        send_read();
                    end
                end
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    act = action_t'($urandom_range(0, 3));
                    if (act == ACT_READ) begin
                        send_read();
                    end else begin
                        send_request(act, DIR_W'($urandom), ROW_W'($urandom),
                                     IN_COL_W'($urandom));
                    end
                end
            end
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (2 * CELLS) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/twfm_pkg.sv
hw/rtl/twfm_ram.sv
hw/rtl/twfm_ctrl.sv
hw/rtl/twfm_dp.sv
hw/rtl/tile_wipe_fade_mask.sv
verif/tb_top.sv
